// ===== hw/rtl/srr_pkg.sv =====
// Shared constants and types of the selective-repeat receiver.
// No dependencies; imported by srr_ctrl, srr_datapath and the top level.
package srr_pkg;

    localparam int WINDOW_LEN = 8;
    localparam int SEQ_BITS   = 4;

    localparam int IDX_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SEQ_IN_W   = 4;
    localparam int PAYLOAD_W  = 64;
    localparam int TDATA_W    = ((SEQ_IN_W + PAYLOAD_W + 7) / 8) * 8;

    typedef struct packed {
        logic capture;
        logic buffer_write;
        logic load_ack;
        logic load_deliv;
    } dp_cmd_t;

    typedef struct packed {
        logic pkt_ok;
        logic in_window;
        logic behind_ok;
        logic is_expected;
        logic out_free;
        logic deliv_last;
    } dp_status_t;

endpackage

// ===== hw/rtl/srr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/srr_ctrl.sv =====
// Request sequencer of the selective-repeat receiver: capture, classify,
// acknowledge, then drain in-order slots. Depends on srr_pkg.
module srr_ctrl
    import srr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EVAL  = 4'b0010,
        ST_ACK   = 4'b0100,
        ST_DELIV = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        cmd              = '0;
        s_tready         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.buffer_write = status.pkt_ok && status.in_window;
                if (status.pkt_ok && (status.in_window || status.behind_ok)) begin
                    state_next = ST_ACK;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_ACK: begin
                if (status.out_free) begin
                    cmd.load_ack = 1'b1;
                    if (status.in_window && status.is_expected) begin
                        state_next = ST_DELIV;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DELIV: begin
                if (status.out_free) begin
                    cmd.load_deliv = 1'b1;
                    if (status.deliv_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/srr_datapath.sv =====
// Datapath of the selective-repeat receiver: packet capture, window math,
// ring state, payload buffer and output register. Depends on srr_pkg, srr_ram.
module srr_datapath
    import srr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  logic                 in_ok,
    input  logic [SEQ_IN_W-1:0]  in_seq,
    input  logic [PAYLOAD_W-1:0] in_payload,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_kind,
    output logic [SEQ_IN_W-1:0]  out_num,
    output logic [PAYLOAD_W-1:0] out_data,
    output logic                 out_last
);

    logic                 ok_reg;
    logic [SEQ_BITS-1:0]  seq_reg;
    logic [PAYLOAD_W-1:0] payload_reg;

    logic [SEQ_BITS-1:0]  next_exp_reg, next_exp_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [WINDOW_LEN-1:0] filled_reg, filled_next;

    logic                 out_valid_reg;
    logic                 out_kind_reg;
    logic [SEQ_IN_W-1:0]  out_num_reg;
    logic [PAYLOAD_W-1:0] out_data_reg;
    logic                 out_last_reg;

    logic [SEQ_BITS-1:0]   ahead, behind;
    logic [IDX_W:0]        slot_sum;
    logic [IDX_W-1:0]      slot;
    logic [IDX_W-1:0]      head_inc;
    logic [WINDOW_LEN-1:0] filled_after;
    logic [PAYLOAD_W-1:0]  rdata;
    logic                  out_free;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ok_reg      <= in_ok;
            seq_reg     <= SEQ_BITS'(in_seq);
            payload_reg <= in_payload;
        end
    end

    // window classification
    always_comb begin
        ahead    = seq_reg - next_exp_reg;
        behind   = next_exp_reg - seq_reg;
        slot_sum = {1'b0, head_reg} + (IDX_W + 1)'(ahead);
        if (slot_sum >= (IDX_W + 1)'(WINDOW_LEN)) begin
            slot = IDX_W'(slot_sum - (IDX_W + 1)'(WINDOW_LEN));
        end else begin
            slot = IDX_W'(slot_sum);
        end
        if (32'(head_reg) == 32'(WINDOW_LEN - 1)) begin
            head_inc = '0;
        end else begin
            head_inc = IDX_W'(32'(head_reg) + 32'd1);
        end
        filled_after           = filled_reg;
        filled_after[head_reg] = 1'b0;
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        status.pkt_ok      = ok_reg;
        status.in_window   = 32'(ahead) < 32'(WINDOW_LEN);
        status.behind_ok   = 32'(behind) <= 32'(WINDOW_LEN);
        status.is_expected = (ahead == '0);
        status.out_free    = out_free;
        status.deliv_last  = !filled_after[head_inc];
    end

    // ring state
    always_comb begin
        next_exp_next = next_exp_reg;
        head_next     = head_reg;
        filled_next   = filled_reg;
        if (cmd.buffer_write) begin
            filled_next[slot] = 1'b1;
        end
        if (cmd.load_deliv) begin
            filled_next   = filled_after;
            head_next     = head_inc;
            next_exp_next = next_exp_reg + SEQ_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_exp_reg <= '0;
            head_reg     <= '0;
            filled_reg   <= '0;
        end else begin
            next_exp_reg <= next_exp_next;
            head_reg     <= head_next;
            filled_reg   <= filled_next;
        end
    end

    // read port follows the next head, so rdata holds the data of the current head
    srr_ram #(
        .WIDTH (PAYLOAD_W),
        .DEPTH (WINDOW_LEN)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (cmd.buffer_write),
        .waddr (slot),
        .wdata (payload_reg),
        .raddr (head_next),
        .rdata (rdata)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_ack || cmd.load_deliv) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_ack) begin
            out_kind_reg <= 1'b0;
            out_num_reg  <= SEQ_IN_W'(32'(seq_reg));
            out_data_reg <= '0;
            out_last_reg <= !(status.in_window && status.is_expected);
        end else if (cmd.load_deliv) begin
            out_kind_reg <= 1'b1;
            out_num_reg  <= SEQ_IN_W'(32'(next_exp_reg));
            out_data_reg <= rdata;
            out_last_reg <= status.deliv_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_num   = out_num_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== hw/rtl/selective_repeat_receiver.sv =====
// Top level of the selective-repeat ARQ receiver: stream ports around the
// sequencer and datapath. Depends on srr_pkg, srr_ctrl, srr_datapath.
//
//  channel  dir  tdata (low bit up)                tuser          tlast
//  s_       in   seq_num[3:0], payload[67:4], pad  checksum_ok    -
//  m_       out  ack_num[3:0], data[67:4], pad     kind           last
//
// A packet is captured in ST_IDLE and classified in ST_EVAL; an
// acknowledgement is then loaded in ST_ACK, and each in-order payload in
// ST_DELIV, one at a time through the single read port of the slot buffer.
// A dropped packet goes from ST_EVAL straight back to ST_IDLE.
// Synchronous active-low reset clears sequence state, slot flags and m_tvalid.
// A stalled m_tready holds the sequencer; a new packet is taken while the
// last result still waits in the output register.
module selective_repeat_receiver
    import srr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // seq_num, payload, zero pad
    input  logic [0:0]         s_tuser,   // checksum_ok
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // ack_num, data, zero pad
    output logic [0:0]         m_tuser,   // kind
    output logic               m_tlast
);

    dp_cmd_t              cmd;
    dp_status_t           status;
    logic                 out_kind;
    logic [SEQ_IN_W-1:0]  out_num;
    logic [PAYLOAD_W-1:0] out_data;

    srr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    srr_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .in_ok      (s_tuser[0]),
        .in_seq     (s_tdata[SEQ_IN_W-1:0]),
        .in_payload (s_tdata[SEQ_IN_W+PAYLOAD_W-1:SEQ_IN_W]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (out_kind),
        .out_num    (out_num),
        .out_data   (out_data),
        .out_last   (m_tlast)
    );

    assign m_tuser = out_kind;
    assign m_tdata = TDATA_W'({out_data, out_num});

endmodule
